// ===== rtl/ctic_pkg.sv =====
// Shared types and constants for the CIA-style timer and interrupt controller.
`timescale 1ns / 1ps

package ctic_pkg;

  // Number of byte registers and the offset width.
  localparam int unsigned NumRegs = 16;
  localparam int unsigned OfsW    = 4;

  // Register offsets.
  localparam logic [OfsW-1:0] OFS_TA_LO = 4'd4;
  localparam logic [OfsW-1:0] OFS_TA_HI = 4'd5;
  localparam logic [OfsW-1:0] OFS_TB_LO = 4'd6;
  localparam logic [OfsW-1:0] OFS_TB_HI = 4'd7;
  localparam logic [OfsW-1:0] OFS_ICR   = 4'd13;
  localparam logic [OfsW-1:0] OFS_CRA   = 4'd14;
  localparam logic [OfsW-1:0] OFS_CRB   = 4'd15;

  // Control register bit positions.
  localparam int unsigned CrRunBit     = 0;
  localparam int unsigned CrOneShotBit = 3;
  localparam int unsigned CrLoadBit    = 4;

  // Interrupt control register bit positions.
  localparam int unsigned IcrSetBit = 7;

  // Interrupt source bit positions within the raised flags.
  localparam int unsigned SrcTaBit    = 0;
  localparam int unsigned SrcTbBit    = 1;
  localparam int unsigned SrcFrameBit = 2;

  // Operation codes.
  typedef enum logic [2:0] {
    OP_WRITE = 3'd0,
    OP_READ  = 3'd1,
    OP_TICK  = 3'd2,
    OP_CHECK = 3'd3,
    OP_FRAME = 3'd4
  } ctic_op_e;

  // Commands from the register decode to one timer.
  typedef struct packed {
    logic tick;
    logic wr_lo;
    logic wr_hi;
    logic wr_ctrl;
  } ctic_tmr_cmd_t;

endpackage

// ===== rtl/ctic_timer.sv =====
// One 16-bit down timer with latch, run bit, load strobe and one-shot mode.
`timescale 1ns / 1ps

module ctic_timer (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ctic_pkg::ctic_tmr_cmd_t cmd_i,
  input  logic [7:0]             data_i,
  input  logic                   one_shot_i,
  output logic                   underflow_o
);
  import ctic_pkg::*;

  logic [15:0] count_q, count_d;
  logic [15:0] latch_q, latch_d;
  logic        run_q, run_d;

  // Latch and counter updates for byte writes, control writes and ticks.
  always_comb begin
    count_d     = count_q;
    latch_d     = latch_q;
    run_d       = run_q;
    underflow_o = 1'b0;
    if (cmd_i.wr_lo) begin
      latch_d[7:0] = data_i;
    end
    if (cmd_i.wr_hi) begin
      latch_d[15:8] = data_i;
      if (!run_q) begin
        count_d[15:8] = data_i;
      end
    end
    if (cmd_i.wr_ctrl) begin
      run_d = data_i[CrRunBit];
      if (data_i[CrLoadBit]) begin
        count_d = latch_q;
      end
    end
    if (cmd_i.tick && run_q) begin
      if (count_q == 16'd0) begin
        underflow_o = 1'b1;
        if (one_shot_i) begin
          run_d = 1'b0;
        end else begin
          count_d = latch_q;
        end
      end else begin
        count_d = count_q - 16'd1;
      end
    end
  end

  // Timer state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      latch_q <= '0;
      run_q   <= 1'b0;
    end else begin
      count_q <= count_d;
      latch_q <= latch_d;
      run_q   <= run_d;
    end
  end

endmodule

// ===== rtl/cia_timer_interrupt_controller.sv =====
// Top level: register file, interrupt control and result register.
//
//  Channel | Direction | Handshake               | Payload
//  in      | input     | in_valid_i / in_ready_o | opcode_i, reg_offset_i, write_data_i
//  out     | output    | out_valid_o/out_ready_i | read_data_o, irq_n_o
//
// Each transfer on the input is decoded and applied to the state in the cycle it
// is accepted, and its result is registered in the output register. The block
// takes one item every cycle; the only limit is the single result register, so a
// stalled output holds off input until the result is taken. Reset clears the
// register file, timers, enable mask, interrupt flags and valid, not the result.
`timescale 1ns / 1ps

module cia_timer_interrupt_controller (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] opcode_i,
  input  logic [3:0] reg_offset_i,
  input  logic [7:0] write_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] read_data_o,
  output logic       irq_n_o
);
  import ctic_pkg::*;

  logic              accept;
  ctic_op_e          op;
  logic [OfsW-1:0]   ofs;
  logic [7:0]        wdata;

  logic [7:0]        regs_q [NumRegs];
  logic [7:0]        regs_d [NumRegs];
  logic [6:0]        mask_q, mask_d;
  logic [3:0]        raised_q, raised_d;
  logic              pend_q, pend_d;
  logic              out_valid_q;
  logic [7:0]        rdata_q, rdata_d;
  logic              irq_n_q;
  logic [3:0]        active;

  ctic_tmr_cmd_t     cmd_a, cmd_b;
  logic              uf_a, uf_b;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign op         = ctic_op_e'(opcode_i);
  assign ofs        = reg_offset_i;
  assign wdata      = write_data_i;
  assign active     = raised_q & mask_q[3:0];

  // Timer command decode.
  always_comb begin
    cmd_a = '0;
    cmd_b = '0;
    if (accept) begin
      cmd_a.tick    = (op == OP_TICK);
      cmd_b.tick    = (op == OP_TICK);
      cmd_a.wr_lo   = (op == OP_WRITE) && (ofs == OFS_TA_LO);
      cmd_a.wr_hi   = (op == OP_WRITE) && (ofs == OFS_TA_HI);
      cmd_a.wr_ctrl = (op == OP_WRITE) && (ofs == OFS_CRA);
      cmd_b.wr_lo   = (op == OP_WRITE) && (ofs == OFS_TB_LO);
      cmd_b.wr_hi   = (op == OP_WRITE) && (ofs == OFS_TB_HI);
      cmd_b.wr_ctrl = (op == OP_WRITE) && (ofs == OFS_CRB);
    end
  end

  ctic_timer u_timer_a (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_a),
    .data_i      (wdata),
    .one_shot_i  (regs_q[OFS_CRA][CrOneShotBit]),
    .underflow_o (uf_a)
  );

  ctic_timer u_timer_b (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_b),
    .data_i      (wdata),
    .one_shot_i  (regs_q[OFS_CRB][CrOneShotBit]),
    .underflow_o (uf_b)
  );

  // Register file, enable mask, interrupt flags and read data.
  always_comb begin
    regs_d   = regs_q;
    mask_d   = mask_q;
    raised_d = raised_q;
    pend_d   = pend_q;
    rdata_d  = 8'd0;
    if (accept) begin
      unique case (op)
        OP_WRITE: begin
          // Timer byte offsets go to the timers only and are not stored.
          if (!(ofs == OFS_TA_LO || ofs == OFS_TA_HI ||
                ofs == OFS_TB_LO || ofs == OFS_TB_HI)) begin
            regs_d[ofs] = wdata;
          end
          if (ofs == OFS_ICR) begin
            if (wdata[IcrSetBit]) begin
              mask_d = mask_q | wdata[6:0];
            end else begin
              mask_d = mask_q & ~wdata[6:0];
            end
          end
        end
        OP_READ: begin
          if (ofs == OFS_ICR) begin
            // Reading the ICR acknowledges and releases the IRQ line.
            rdata_d  = {|active, 3'd0, active};
            raised_d = '0;
            pend_d   = 1'b0;
          end else begin
            rdata_d = regs_q[ofs];
          end
        end
        OP_TICK: begin
          if (uf_a && mask_q[SrcTaBit]) begin
            raised_d[SrcTaBit] = 1'b1;
          end
          if (uf_b && mask_q[SrcTbBit]) begin
            raised_d[SrcTbBit] = 1'b1;
          end
        end
        OP_CHECK: begin
          if (!pend_q && (mask_q != 7'd0)) begin
            if (|active) begin
              pend_d = 1'b1;
            end else begin
              raised_d = '0;
            end
          end
        end
        OP_FRAME: begin
          if (!pend_q) begin
            raised_d[SrcFrameBit] = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) begin
        regs_q[i] <= '0;
      end
      mask_q      <= '0;
      raised_q    <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      regs_q   <= regs_d;
      mask_q   <= mask_d;
      raised_q <= raised_d;
      pend_q   <= pend_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rdata_q <= rdata_d;
      irq_n_q <= !pend_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign read_data_o = rdata_q;
  assign irq_n_o     = irq_n_q;

`ifndef SYNTHESIS
  // An accepted ICR read always reports the IRQ line released.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && op == OP_READ && ofs == OFS_ICR) |=> (out_valid_o && irq_n_o))
    else $error("IRQ still asserted after ICR read");

  // Only the three defined sources can ever be raised.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !raised_q[3])
    else $error("undefined interrupt source raised");

  // The timer byte offsets are never stored in the register file.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (regs_q[OFS_TA_LO] | regs_q[OFS_TA_HI] | regs_q[OFS_TB_LO] |
     regs_q[OFS_TB_HI]) == 8'd0)
    else $error("timer byte offset stored in register file");

  // The output reflects the pending state left by the accepted item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (irq_n_o == !pend_q))
    else $error("IRQ output disagrees with pending state");
`endif

endmodule
